@@ rtl/core/credit_rate_feedback_control_unit_macros.svh @@
// ----------------------------------------------------------------------------
// Credit rate feedback control - assertion macros
// Concurrent checks on clk, disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef CREDIT_RATE_FEEDBACK_CONTROL_UNIT_MACROS_SVH
`define CREDIT_RATE_FEEDBACK_CONTROL_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define CRFC_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define CRFC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define CRFC_ASSERT_IMPL(label, ante, cons, msg)
`define CRFC_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

@@ rtl/core/crfc_pkg.sv @@
// ----------------------------------------------------------------------------
// Credit rate feedback control - package
// Widths, codes, unit request types and the rate saturation helper.
// ----------------------------------------------------------------------------
package crfc_pkg;

  localparam int SEQ_W       = 48;
  localparam int RATE_W      = 40;
  localparam int Q_W         = 17;
  localparam int LOSS_W      = 16;
  localparam int SUM_W       = 44;
  localparam int MUL_A_W     = 48;
  localparam int MUL_B_W     = 19;
  localparam int MUL_DIGIT_W = 16;
  localparam int MUL_DIGITS  = MUL_A_W / MUL_DIGIT_W;
  localparam int MUL_P_W     = MUL_A_W + MUL_B_W;
  localparam int DIV_STEPS   = 16;

  localparam logic [Q_W-1:0]    Q16_ONE  = 17'h10000;
  localparam logic [RATE_W-1:0] RATE_MAX = 40'hFF_FFFF_FFFF;

  typedef enum logic [1:0] {
    CMD_CREDIT_SENT = 2'd0,
    CMD_DATA_RX     = 2'd1,
    CMD_START       = 2'd2,
    CMD_UNUSED      = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_INC   = 2'd1,
    ACT_DEC   = 2'd2,
    ACT_START = 2'd3
  } action_t;

  localparam logic [2:0] REG_MAX_RATE  = 3'd0;
  localparam logic [2:0] REG_INIT_RATE = 3'd1;
  localparam logic [2:0] REG_TARGET    = 3'd2;
  localparam logic [2:0] REG_MAX_AGGR  = 3'd3;
  localparam logic [2:0] REG_MIN_AGGR  = 3'd4;
  localparam logic [2:0] REG_INIT_AGGR = 3'd5;

  typedef struct packed {
    logic               start;
    logic [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic               done;
    logic [MUL_P_W-1:0] prod;
  } mul_rsp_t;

  typedef struct packed {
    logic             start;
    logic [SEQ_W-1:0] rem;
    logic [SEQ_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [LOSS_W-1:0] quot;
  } div_rsp_t;

  function automatic logic [RATE_W-1:0] sat_rate(input logic [SUM_W-1:0] v);
    logic [RATE_W-1:0] r;
    r = (v > SUM_W'(RATE_MAX)) ? RATE_MAX : v[RATE_W-1:0];
    return r;
  endfunction

endpackage

@@ rtl/core/crfc_mul.sv @@
// ----------------------------------------------------------------------------
// Credit rate feedback control - iterative multiplier
// 48 x 19 bit product, one 16 bit digit of the first operand per cycle.
// ----------------------------------------------------------------------------
module crfc_mul
  import crfc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  mul_req_t req,
  output mul_rsp_t rsp
);

  localparam int CNT_W = $clog2(MUL_DIGITS);

  logic [MUL_A_W-1:0]             a;
  logic [MUL_B_W-1:0]             b;
  logic [MUL_P_W-1:0]             acc;
  logic [MUL_P_W-1:0]             acc_next;
  logic [MUL_DIGIT_W+MUL_B_W-1:0] part;
  logic [CNT_W-1:0]               cnt;
  logic                           busy;
  logic                           done;

  assign part     = a[MUL_A_W-1 -: MUL_DIGIT_W] * b;
  assign acc_next = {acc[MUL_P_W-MUL_DIGIT_W-1:0], {MUL_DIGIT_W{1'b0}}}
                  + MUL_P_W'(part);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        a    <= req.a;
        b    <= req.b;
        acc  <= '0;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        acc <= acc_next;
        a   <= {a[MUL_A_W-MUL_DIGIT_W-1:0], {MUL_DIGIT_W{1'b0}}};
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(MUL_DIGITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.prod = acc;

endmodule

@@ rtl/core/crfc_div.sv @@
// ----------------------------------------------------------------------------
// Credit rate feedback control - loss ratio divider
// Restoring divider, one quotient bit per cycle, 16 bit fractional quotient.
// ----------------------------------------------------------------------------
module crfc_div
  import crfc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int CNT_W = $clog2(DIV_STEPS);

  logic [SEQ_W:0]    rem;
  logic [SEQ_W-1:0]  den;
  logic [LOSS_W-1:0] quot;
  logic [SEQ_W:0]    shifted;
  logic              fits;
  logic [CNT_W-1:0]  cnt;
  logic              busy;
  logic              done;

  assign shifted = {rem[SEQ_W-1:0], 1'b0};
  assign fits    = shifted >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        rem  <= {1'b0, req.rem};
        den  <= req.den;
        quot <= '0;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        rem  <= fits ? (shifted - {1'b0, den}) : shifted;
        quot <= {quot[LOSS_W-2:0], fits};
        cnt  <= cnt + 1'b1;
        if (cnt == CNT_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quot = quot;

endmodule

@@ rtl/core/credit_rate_feedback_control_unit.sv @@
// ----------------------------------------------------------------------------
// Credit rate feedback control unit
// Receiver-side credit rate controller: credit numbering, loss rounds, rate.
// ----------------------------------------------------------------------------
// One item is taken at a time; the input side is ready only while the
// sequencer is idle, and a finished result waits in the output register
// while the next item is taken. Credit-sent, unknown and non-update
// data-received items use neither the multiplier nor the divider; a start
// item makes one pass of the shared 3-digit multiplier. An update round
// that needs the 16-step loss divider makes two multiplier passes when it
// cuts the rate and three when it raises it; a round with no loss skips
// the divider.
// Configuration registers lie at byte addresses 8*i, 64 bit data.
`include "credit_rate_feedback_control_unit_macros.svh"

module credit_rate_feedback_control_unit
  import crfc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // rx_credit_seq[47:0]
  input  logic [1:0]  s_tuser,   // cmd[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [87:0] m_tdata,   // issued_credit_seq[47:0], credit_rate_now[87:48]
  output logic [1:0]  m_tuser,   // rate_action[1:0]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_EXEC, ST_DIV, ST_ADJ, ST_INC_A, ST_INC_B, ST_INC_C, ST_INC_D,
    ST_DEC_A, ST_DEC_B, ST_DEC_C, ST_START_W, ST_DONE
  } state_t;

  state_t state;

  logic [RATE_W-1:0] max_credit_rate;
  logic [Q_W-1:0]    init_rate_ratio;
  logic [Q_W-1:0]    target_loss;
  logic [Q_W-1:0]    max_aggressiveness;
  logic [Q_W-1:0]    min_aggressiveness;
  logic [Q_W-1:0]    init_aggressiveness;

  logic [SEQ_W-1:0]  next_seq;
  logic [SEQ_W-1:0]  arrival_count;
  logic [SEQ_W-1:0]  last_update_seq;
  logic [SEQ_W-1:0]  next_update_seq;
  logic [RATE_W-1:0] current_rate;
  logic [Q_W-1:0]    aggressiveness;
  action_t           previous_action;

  cmd_t              in_cmd;
  logic [SEQ_W-1:0]  in_seq;
  logic [SEQ_W-1:0]  res_seq;
  logic [RATE_W-1:0] res_rate;
  action_t           res_act;
  logic [LOSS_W-1:0] loss;
  logic [Q_W-1:0]    a_sel;
  logic [RATE_W:0]   t1;

  logic [SEQ_W-1:0]  arr_next;
  logic [SEQ_W-1:0]  sent;
  logic              round_due;
  logic              need_div;
  logic [Q_W-1:0]    a_cur;
  logic [Q_W-1:0]    half_aggr;
  logic [Q_W:0]      aggr_sum;
  logic [MUL_B_W-1:0] one_plus_target;
  logic [RATE_W-1:0] rate_inc;
  logic [RATE_W-1:0] rate_dec;
  logic [RATE_W-1:0] rate_start;
  logic              wr_en;

  mul_req_t mul_req;
  mul_rsp_t mul_rsp;
  div_req_t div_req;
  div_rsp_t div_rsp;

  crfc_mul u_mul (.clk(clk), .rst(rst), .req(mul_req), .rsp(mul_rsp));
  crfc_div u_div (.clk(clk), .rst(rst), .req(div_req), .rsp(div_rsp));

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_credit_rate     <= '0;
      init_rate_ratio     <= 17'd65536;
      target_loss         <= 17'd19661;
      max_aggressiveness  <= 17'd32768;
      min_aggressiveness  <= 17'd655;
      init_aggressiveness <= 17'd32768;
    end else if (wr_en) begin
      unique case (paddr[5:3])
        REG_MAX_RATE:  max_credit_rate     <= pwdata[RATE_W-1:0];
        REG_INIT_RATE: init_rate_ratio     <= pwdata[Q_W-1:0];
        REG_TARGET:    target_loss         <= pwdata[Q_W-1:0];
        REG_MAX_AGGR:  max_aggressiveness  <= pwdata[Q_W-1:0];
        REG_MIN_AGGR:  min_aggressiveness  <= pwdata[Q_W-1:0];
        REG_INIT_AGGR: init_aggressiveness <= pwdata[Q_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[5:3])
      REG_MAX_RATE:  prdata = 64'(max_credit_rate);
      REG_INIT_RATE: prdata = 64'(init_rate_ratio);
      REG_TARGET:    prdata = 64'(target_loss);
      REG_MAX_AGGR:  prdata = 64'(max_aggressiveness);
      REG_MIN_AGGR:  prdata = 64'(min_aggressiveness);
      REG_INIT_AGGR: prdata = 64'(init_aggressiveness);
      default:       prdata = '0;
    endcase
  end

  assign s_tready        = (state == ST_IDLE);
  assign arr_next        = (in_seq > last_update_seq) ? arrival_count + 1'b1 : arrival_count;
  assign sent            = in_seq - last_update_seq;
  assign round_due       = (in_seq >= next_update_seq) && (next_update_seq != '0);
  assign need_div        = (sent != '0) && (arr_next < sent);
  assign a_cur           = (aggressiveness > Q16_ONE) ? Q16_ONE : aggressiveness;
  assign half_aggr       = aggressiveness >> 1;
  assign aggr_sum        = {1'b0, aggressiveness} + {1'b0, max_aggressiveness};
  assign one_plus_target = MUL_B_W'(Q16_ONE) + MUL_B_W'(target_loss);
  assign rate_inc        = sat_rate(SUM_W'(t1) + SUM_W'(mul_rsp.prod[58:16]));
  assign rate_dec        = sat_rate(SUM_W'(mul_rsp.prod[58:16]));
  assign rate_start      = sat_rate(SUM_W'(mul_rsp.prod[56:16]));

  always_comb begin
    mul_req = '0;
    div_req = '0;
    unique case (state)
      ST_EXEC: begin
        if (in_cmd == CMD_START) begin
          mul_req.start = 1'b1;
          mul_req.a     = MUL_A_W'(max_credit_rate);
          mul_req.b     = MUL_B_W'(init_rate_ratio);
        end
        if (in_cmd == CMD_DATA_RX && round_due && need_div) begin
          div_req.start = 1'b1;
          div_req.rem   = sent - arr_next;
          div_req.den   = sent;
        end
      end
      ST_INC_A: begin
        mul_req.start = 1'b1;
        mul_req.a     = MUL_A_W'(current_rate);
        mul_req.b     = MUL_B_W'(Q16_ONE - a_cur);
      end
      ST_INC_B: begin
        mul_req.start = mul_rsp.done;
        mul_req.a     = MUL_A_W'(max_credit_rate);
        mul_req.b     = one_plus_target;
      end
      ST_INC_C: begin
        mul_req.start = mul_rsp.done;
        mul_req.a     = mul_rsp.prod[63:16];
        mul_req.b     = MUL_B_W'(a_sel);
      end
      ST_DEC_A: begin
        mul_req.start = 1'b1;
        mul_req.a     = MUL_A_W'(Q16_ONE - {1'b0, loss});
        mul_req.b     = one_plus_target;
      end
      ST_DEC_B: begin
        mul_req.start = mul_rsp.done;
        mul_req.a     = MUL_A_W'(current_rate);
        mul_req.b     = mul_rsp.prod[34:16];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      m_tvalid        <= 1'b0;
      next_seq        <= SEQ_W'(1);
      arrival_count   <= '0;
      last_update_seq <= '0;
      next_update_seq <= '0;
      current_rate    <= '0;
      aggressiveness  <= 17'd32768;
      previous_action <= ACT_NONE;
    end else begin
      if (m_tvalid && m_tready && state != ST_DONE) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            in_cmd <= cmd_t'(s_tuser);
            in_seq <= s_tdata;
            state  <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          res_rate <= current_rate;
          res_act  <= ACT_NONE;
          unique case (in_cmd)
            CMD_CREDIT_SENT: begin
              res_seq  <= next_seq;
              next_seq <= next_seq + 1'b1;
              state    <= ST_DONE;
            end
            CMD_DATA_RX: begin
              res_seq       <= '0;
              arrival_count <= round_due ? '0 : arr_next;
              if (in_seq >= next_update_seq) begin
                next_update_seq <= next_seq;
              end
              if (round_due) begin
                last_update_seq <= in_seq;
                loss            <= '0;
                state           <= need_div ? ST_DIV : ST_ADJ;
              end else begin
                state <= ST_DONE;
              end
            end
            CMD_START: begin
              res_seq        <= '0;
              aggressiveness <= init_aggressiveness;
              state          <= ST_START_W;
            end
            default: begin
              res_seq <= '0;
              state   <= ST_DONE;
            end
          endcase
        end
        ST_DIV: begin
          if (div_rsp.done) begin
            loss  <= div_rsp.quot;
            state <= ST_ADJ;
          end
        end
        ST_ADJ: begin
          if ({1'b0, loss} <= target_loss) begin
            if (previous_action == ACT_INC) begin
              aggressiveness <= aggr_sum[Q_W:1];
            end
            state <= ST_INC_A;
          end else begin
            state <= ST_DEC_A;
          end
        end
        ST_INC_A: begin
          a_sel <= a_cur;
          state <= ST_INC_B;
        end
        ST_INC_B: begin
          if (mul_rsp.done) begin
            t1    <= mul_rsp.prod[56:16];
            state <= ST_INC_C;
          end
        end
        ST_INC_C: begin
          if (mul_rsp.done) begin
            state <= ST_INC_D;
          end
        end
        ST_INC_D: begin
          if (mul_rsp.done) begin
            current_rate    <= rate_inc;
            res_rate        <= rate_inc;
            res_act         <= ACT_INC;
            previous_action <= ACT_INC;
            state           <= ST_DONE;
          end
        end
        ST_DEC_A: begin
          aggressiveness <= (half_aggr > min_aggressiveness) ? half_aggr : min_aggressiveness;
          state          <= ST_DEC_B;
        end
        ST_DEC_B: begin
          if (mul_rsp.done) begin
            state <= ST_DEC_C;
          end
        end
        ST_DEC_C: begin
          if (mul_rsp.done) begin
            current_rate    <= rate_dec;
            res_rate        <= rate_dec;
            res_act         <= ACT_DEC;
            previous_action <= ACT_DEC;
            state           <= ST_DONE;
          end
        end
        ST_START_W: begin
          if (mul_rsp.done) begin
            current_rate <= rate_start;
            res_rate     <= rate_start;
            res_act      <= ACT_START;
            state        <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {res_rate, res_seq};
            m_tuser  <= res_act;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `CRFC_ASSERT_NEXT(a_accept_exec, s_tvalid && s_tready, state == ST_EXEC, "item not executed")
  `CRFC_ASSERT_IMPL(a_mul_done_wait, mul_rsp.done, state == ST_INC_B || state == ST_INC_C || state == ST_INC_D || state == ST_DEC_B || state == ST_DEC_C || state == ST_START_W, "product lost")
  `CRFC_ASSERT_NEXT(a_dec_floor, state == ST_DEC_A, aggressiveness >= min_aggressiveness, "aggressiveness below floor")

endmodule
